### src/rrtd_pkg.sv
`default_nettype none
package rrtd_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned SidW    = 31;
  localparam int unsigned CountW  = 32;
  localparam int unsigned WinW    = 16;
  localparam int unsigned SlotInW = 3;
  localparam int unsigned MaxOut  = 8;

  localparam logic [TimeW-1:0]  NsPerSec = 64'd1_000_000_000;
  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic ReqPacket = 1'b0;
  localparam logic ReqRule   = 1'b1;

  // one-hot sequencer states
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CLEAR = 7'b0000010,
    ST_MATCH = 7'b0000100,
    ST_READ  = 7'b0001000,
    ST_UPD   = 7'b0010000,
    ST_EMIT  = 7'b0100000,
    ST_FLUSH = 7'b1000000
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] tag;
    logic [TimeW-1:0] start;
    logic [CountW-1:0] count;
    logic             alerted;
  } slot_t;

endpackage
`default_nettype wire

### src/rule_rate_threshold_detector.sv
// Flow: a packet scans the rules in MATCH, a match runs READ and UPD, each alert after the
//   first runs EMIT, then FLUSH, held by output stalls; a rule write sweeps its slots in CLEAR.
// Throughput: one item at a time; in_stall is high until the last result is loaded or the sweep ends.
// The window length (window_secs * 1e9) is built by a 16-step shift-and-add per matching rule.
// Reset: synchronous, active low; after reset a sweep of all RULES*TRACK_SLOTS entries clears
//   the slot memory, during which no item is taken.
`default_nettype none
module rule_rate_threshold_detector
  import rrtd_pkg::*;
#(
  parameter int unsigned RULES       = 8,
  // power of two: the slot index is the low address bits
  parameter int unsigned TRACK_SLOTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_req_type,
  input  wire logic [TimeW-1:0]   in_time_ns,
  input  wire logic [AddrW-1:0]   in_src_addr,
  input  wire logic [AddrW-1:0]   in_dst_addr,
  input  wire logic [7:0]         in_protocol,
  input  wire logic [15:0]        in_src_port,
  input  wire logic [15:0]        in_dst_port,
  input  wire logic [SlotInW-1:0] in_rule_slot,
  input  wire logic [SidW-1:0]    in_rule_sid,
  input  wire logic               in_track_by_dst,
  input  wire logic [CountW-1:0]  in_count_limit,
  input  wire logic [WinW-1:0]    in_window_secs,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [SidW-1:0]         out_alert_sid,
  output logic                    out_last_alert
);

  localparam int unsigned RuleW  = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int unsigned TsW    = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int unsigned Depth  = RULES * TRACK_SLOTS;
  localparam int unsigned MemW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned MulW   = $clog2(WinW + 1);
  localparam int unsigned NW     = $clog2(MaxOut + 1);

  // rule table (flops, read at the scan index)
  logic [RULES-1:0]  rule_used_r;
  logic [7:0]        rule_proto_r  [RULES];
  logic [AddrW-1:0]  rule_src_r    [RULES];
  logic [AddrW-1:0]  rule_dst_r    [RULES];
  logic [15:0]       rule_sport_r  [RULES];
  logic [15:0]       rule_dport_r  [RULES];
  logic [SidW-1:0]   rule_ident_r  [RULES];
  logic              rule_by_dst_r [RULES];
  logic [CountW-1:0] rule_limit_r  [RULES];
  logic [WinW-1:0]   rule_window_r [RULES];

  // slot memory
  slot_t slot_mem [Depth];
  slot_t rd_r;

  state_t state_r;
  logic [MemW:0]      clr_r;
  logic [RuleW:0]     rix_r;
  logic [TsW:0]       six_r;
  logic [MemW-1:0]    maddr_r;
  logic [TimeW-1:0]   now_r, win_r;
  logic [AddrW-1:0]   src_r, dst_r, addr_r;
  logic [7:0]         proto_r;
  logic [15:0]        sport_r, dport_r;
  logic [WinW-1:0]    wsec_r;
  logic [MulW-1:0]    mstep_r;
  logic [NW-1:0]      nout_r;
  logic [SidW-1:0]    pend_sid_r;
  logic               pend_r;
  logic               ov_r, olast_r;
  logic [SidW-1:0]    osid_r;

  logic [RuleW-1:0] ri;
  assign ri = rix_r[RuleW-1:0];

  logic hit;
  always_comb begin
    hit = rule_used_r[ri]
      && (rule_proto_r[ri] == '0 || rule_proto_r[ri] == proto_r)
      && (rule_src_r[ri]   == '0 || rule_src_r[ri]   == src_r)
      && (rule_dst_r[ri]   == '0 || rule_dst_r[ri]   == dst_r)
      && (rule_sport_r[ri] == '0 || rule_sport_r[ri] == sport_r)
      && (rule_dport_r[ri] == '0 || rule_dport_r[ri] == dport_r);
  end

  logic [AddrW-1:0] hit_addr;
  assign hit_addr = rule_by_dst_r[ri] ? dst_r : src_r;

  logic [MemW-1:0] hit_maddr;
  assign hit_maddr = MemW'(ri * TRACK_SLOTS + 32'(hit_addr & AddrW'(TRACK_SLOTS - 1)));

  // slot update
  slot_t upd;
  logic  restart, fire;
  always_comb begin
    restart = !rd_r.valid || rd_r.tag != addr_r || (now_r - rd_r.start) >= win_r;
    upd = rd_r;
    if (restart) begin
      upd = '{valid: 1'b1, tag: addr_r, start: now_r, count: '0, alerted: 1'b0};
    end
    if (upd.count != CountMax) begin
      upd.count = upd.count + 1'b1;
    end
    fire = (upd.count >= rule_limit_r[ri]) && !upd.alerted;
    if (fire) begin
      upd.alerted = 1'b1;
    end
  end

  logic take_alert;
  assign take_alert = fire && nout_r != NW'(MaxOut);

  logic out_free;
  assign out_free = !ov_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid      = ov_r;
  assign out_alert_sid  = osid_r;
  assign out_last_alert = olast_r;

  // load the output register from the pending alert
  logic load_out;
  assign load_out = out_free && (state_r == ST_EMIT || (state_r == ST_FLUSH && pend_r));

  logic last_rule;
  assign last_rule = (rix_r == (RuleW+1)'(RULES - 1));

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      rule_used_r <= '0;
      ov_r        <= 1'b0;
      pend_r      <= 1'b0;
      nout_r      <= '0;
      rix_r       <= '0;
      six_r       <= '0;
      mstep_r     <= '0;
    end else begin
      if (load_out) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            now_r   <= in_time_ns;
            src_r   <= in_src_addr;
            dst_r   <= in_dst_addr;
            proto_r <= in_protocol;
            sport_r <= in_src_port;
            dport_r <= in_dst_port;
            rix_r   <= '0;
            nout_r  <= '0;
            pend_r  <= 1'b0;
            if (in_req_type == ReqRule) begin
              if (32'(in_rule_slot) < RULES) begin
                rule_used_r[RuleW'(in_rule_slot)]   <= 1'b1;
                rule_proto_r[RuleW'(in_rule_slot)]  <= in_protocol;
                rule_src_r[RuleW'(in_rule_slot)]    <= in_src_addr;
                rule_dst_r[RuleW'(in_rule_slot)]    <= in_dst_addr;
                rule_sport_r[RuleW'(in_rule_slot)]  <= in_src_port;
                rule_dport_r[RuleW'(in_rule_slot)]  <= in_dst_port;
                rule_ident_r[RuleW'(in_rule_slot)]  <= in_rule_sid;
                rule_by_dst_r[RuleW'(in_rule_slot)] <= in_track_by_dst;
                rule_limit_r[RuleW'(in_rule_slot)]  <= in_count_limit;
                rule_window_r[RuleW'(in_rule_slot)] <= in_window_secs;
                clr_r   <= (MemW+1)'(32'(RuleW'(in_rule_slot)) * TRACK_SLOTS);
                six_r   <= '0;
                state_r <= ST_CLEAR;
              end
            end else begin
              state_r <= ST_MATCH;
            end
          end
        end
        ST_CLEAR: begin
          // sweep: full memory after reset, one rule's slots after a write
          clr_r <= clr_r + 1'b1;
          six_r <= six_r + 1'b1;
          if (clr_r == (MemW+1)'(Depth - 1) ||
              (rule_used_r != '0 && six_r == (TsW+1)'(TRACK_SLOTS - 1))) begin
            state_r <= ST_IDLE;
          end
        end
        ST_MATCH: begin
          if (hit) begin
            addr_r  <= hit_addr;
            maddr_r <= hit_maddr;
            wsec_r  <= rule_window_r[ri];
            win_r   <= '0;
            mstep_r <= '0;
            state_r <= ST_READ;
          end else if (last_rule) begin
            state_r <= ST_FLUSH;
          end else begin
            rix_r <= rix_r + 1'b1;
          end
        end
        ST_READ: begin
          // shared shift-add builds the window in ns, one bit per cycle
          win_r   <= (win_r << 1) + (wsec_r[WinW-1] ? NsPerSec : '0);
          wsec_r  <= wsec_r << 1;
          mstep_r <= mstep_r + 1'b1;
          if (mstep_r == MulW'(WinW - 1)) begin
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (take_alert && pend_r) begin
            state_r <= ST_EMIT;
          end else begin
            if (take_alert) begin
              pend_r     <= 1'b1;
              pend_sid_r <= rule_ident_r[ri];
            end
            if (last_rule) begin
              state_r <= ST_FLUSH;
            end else begin
              rix_r   <= rix_r + 1'b1;
              state_r <= ST_MATCH;
            end
          end
        end
        ST_EMIT: begin
          // send the older alert, not last, and hold the new one
          if (out_free) begin
            osid_r     <= pend_sid_r;
            olast_r    <= 1'b0;
            pend_sid_r <= rule_ident_r[ri];
            if (last_rule) begin
              state_r <= ST_FLUSH;
            end else begin
              rix_r   <= rix_r + 1'b1;
              state_r <= ST_MATCH;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_r) begin
            state_r <= ST_IDLE;
          end else if (out_free) begin
            osid_r  <= pend_sid_r;
            olast_r <= 1'b1;
            pend_r  <= 1'b0;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      // count alerts that give a result
      if (state_r == ST_UPD && take_alert) begin
        nout_r <= nout_r + 1'b1;
      end
    end
  end

  // slot memory port
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      slot_mem[clr_r[MemW-1:0]] <= '0;
    end else if (state_r == ST_UPD) begin
      slot_mem[maddr_r] <= upd;
    end
    rd_r <= slot_mem[maddr_r];
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_alert_sid))
    else $error("held alert changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD |-> $past(state_r) == ST_READ)
    else $error("update without read");
  assert property (@(posedge clk) disable iff (!rst_n)
    nout_r <= NW'(MaxOut))
    else $error("too many alerts");

endmodule
`default_nettype wire
